// File: design/rbb_pkg.sv
// shared types, constants and the reciprocal table for the rgb box blur
package rbb_pkg;

  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int SUM_W        = 12;
  localparam int CNT_W        = 4;
  localparam int RECIP_SHIFT  = 16;
  localparam int RECIP_W      = 17;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // pixel as {blue, green, red}: channel 2 is blue, channel 0 is red
  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][SUM_W-1:0] chan_sum_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_entry_t;

  // which neighbours of the center fall inside the image, with produce and end-of-frame flags
  typedef struct packed {
    logic produce;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic eof;
  } win_mask_t;

  typedef struct packed {
    logic      shift;
    logic      sum;
    win_mask_t mask;
  } win_ctrl_t;

  // ceil(2^16 / n), exact for sums below 2^12
  function automatic logic [RECIP_W-1:0] recip(input cnt_t n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// File: design/rgb_box_blur_3x3_edge_normalized.sv
// top level: stream position tracking, sequencer and line store read-modify-write
// the result passes through the line store read, the window update and write-back, the masked sum,
// and the divide into the output register
// one word at a time: the sequencer takes no new word until it is through the line store read-modify-write
// and, when the word yields a result, until that result is loaded; a stalled output holds the last step
// reset clears position, window, sequencer and output valid; the line store is not cleared
module rgb_box_blur_3x3_edge_normalized import rbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [PIX_W-1:0]       s_tdata,   // red_in, green_in, blue_in
  input  logic                   s_tuser,   // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [PIX_W-1:0]       m_tdata,   // red_out, green_out, blue_out
  output logic                   m_tlast,   // end_of_frame
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW0 = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WW0 > 1) ? WW0 : 2;
  localparam int EW  = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int EH  = (HW > HEIGHT_REG_W) ? HW : HEIGHT_REG_W;
  localparam int RW  = $clog2(MAX_HEIGHT + 3);

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_SUM, ST_OUT} state_t;

  state_t                    state;
  logic [WIDTH_REG_W-1:0]    width_reg;
  logic [HEIGHT_REG_W-1:0]   height_reg;
  logic [CW-1:0]             in_column;
  logic [RW-1:0]             in_row;
  logic [CW-1:0]             addr_q;
  pix_t                      px_q;
  win_mask_t                 mask_q;

  logic [EW-1:0]  width_ext;
  logic [EH-1:0]  height_ext;
  logic [WW-1:0]  w;
  logic [HW-1:0]  h;
  logic [RW-1:0]  h_r;
  logic [RW-1:0]  h_p1;
  logic           wrap;
  logic [CW-1:0]  c;
  logic [WW-1:0]  c_w;
  logic [WW-1:0]  c_inc;
  logic [RW-1:0]  r_inc;
  logic [RW-1:0]  r;
  logic [RW-1:0]  cr;
  logic           c_pos;
  logic           accept;
  win_mask_t      mask_next;
  logic [CW-1:0]  in_column_next;
  logic [RW-1:0]  in_row_next;
  pix_t           px_in;

  line_entry_t    rd_data;
  line_entry_t    wr_data;
  win_ctrl_t      win_ctrl;
  chan_sum_t      sums;
  cnt_t           count;
  logic           out_free;
  logic           out_load;

  // effective geometry: zero counts as one, saturate at the maximum
  assign width_ext  = EW'(width_reg);
  assign height_ext = EH'(height_reg);
  assign w = (width_reg == '0) ? WW'(1) :
             (width_ext > EW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : width_ext[WW-1:0];
  assign h = (height_reg == '0) ? HW'(1) :
             (height_ext > EH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : height_ext[HW-1:0];
  assign h_r  = RW'(h);
  assign h_p1 = h_r + RW'(1);

  // position of this word, after wrapping for a geometry change
  assign wrap  = WW'(in_column) >= w;
  assign c     = wrap ? '0 : in_column;
  assign r_inc = wrap ? in_row + RW'(1) : in_row;
  assign r     = (r_inc > h_p1) ? '0 : r_inc;
  assign c_w   = WW'(c);
  assign c_inc = c_w + WW'(1);
  assign c_pos = (c != '0);

  // center of the emitted pixel is one row up and one column left
  assign cr = c_pos ? r - RW'(1) : r - RW'(2);

  always_comb begin
    mask_next.produce = c_pos ? (r >= RW'(1) && r <= h_r) : (r >= RW'(2) && r <= h_p1);
    mask_next.top     = (cr != '0);
    mask_next.bottom  = (cr + RW'(1)) < h_r;
    mask_next.left    = c_pos ? (c_w >= WW'(2)) : (w >= WW'(2));
    mask_next.right   = c_pos;
    mask_next.eof     = !c_pos && ((cr + RW'(1)) == h_r);
  end

  always_comb begin
    if (r >= h_p1) begin
      in_column_next = '0;
      in_row_next    = '0;
    end else if (c_inc >= w) begin
      in_column_next = '0;
      in_row_next    = r + RW'(1);
    end else begin
      in_column_next = c_inc[CW-1:0];
      in_row_next    = r;
    end
  end

  assign px_in = (s_tuser == FUNC_FLUSH) ? '0 :
                 {s_tdata[CH_W-1:0], s_tdata[2*CH_W-1:CH_W], s_tdata[3*CH_W-1:2*CH_W]};

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_OUT) && out_free;

  assign wr_data.older = rd_data.newer;
  assign wr_data.newer = px_q;

  assign win_ctrl.shift = (state == ST_UPD);
  assign win_ctrl.sum   = (state == ST_SUM);
  assign win_ctrl.mask  = mask_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_column <= '0;
      in_row    <= '0;
      mask_q    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            in_column <= in_column_next;
            in_row    <= in_row_next;
            mask_q    <= mask_next;
            addr_q    <= c;
            px_q      <= px_in;
            state     <= ST_UPD;
          end
        end
        ST_UPD: begin
          state <= mask_q.produce ? ST_SUM : ST_IDLE;
        end
        ST_SUM: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  rbb_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (c),
    .rd_data (rd_data),
    .wr_en   (state == ST_UPD),
    .wr_addr (addr_q),
    .wr_data (wr_data)
  );

  rbb_window u_window (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (win_ctrl),
    .push_top (rd_data.older),
    .push_mid (rd_data.newer),
    .push_bot (px_q),
    .sums     (sums),
    .count    (count)
  );

  rbb_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .sums     (sums),
    .count    (count),
    .eof      (mask_q.eof),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: design/rbb_line_mem.sv
// two-row line store, one entry per column, registered read
module rbb_line_mem import rbb_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output line_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  line_entry_t       wr_data
);

  line_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// File: design/rbb_window.sv
// 3x3 window registers and masked per-channel neighbourhood sums
module rbb_window import rbb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  win_ctrl_t   ctrl,
  input  pix_t        push_top,
  input  pix_t        push_mid,
  input  pix_t        push_bot,
  output chan_sum_t   sums,
  output cnt_t        count
);

  // win[col][row]: col 0 oldest, row 0 top
  pix_t      win [3][3];
  chan_sum_t sum_c;
  logic [2:0] col_ok;
  logic [2:0] row_ok;
  logic [1:0] cols;
  logic [1:0] rows;

  assign col_ok = {ctrl.mask.right, 1'b1, ctrl.mask.left};
  assign row_ok = {ctrl.mask.bottom, 1'b1, ctrl.mask.top};
  assign cols   = 2'd1 + {1'b0, ctrl.mask.left} + {1'b0, ctrl.mask.right};
  assign rows   = 2'd1 + {1'b0, ctrl.mask.top} + {1'b0, ctrl.mask.bottom};

  always_comb begin
    sum_c = '0;
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        if (col_ok[x] && row_ok[y]) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_c[ch] = sum_c[ch] + SUM_W'(win[x][y][ch*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int x = 0; x < 3; x++) begin
        for (int y = 0; y < 3; y++) begin
          win[x][y] <= '0;
        end
      end
    end else if (ctrl.shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2][0] <= push_top;
      win[2][1] <= push_mid;
      win[2][2] <= push_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      sums  <= sum_c;
      count <= {2'b00, cols} * {2'b00, rows};
    end
  end

endmodule

// File: design/rbb_out.sv
// reciprocal divide of the sums and the output word register
module rbb_out import rbb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  chan_sum_t          sums,
  input  cnt_t               count,
  input  logic               eof,
  output logic               free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [PIX_W-1:0]   m_tdata,  // red, green, blue
  output logic               m_tlast   // end_of_frame
);

  logic [RECIP_W-1:0] rcp;
  logic [PROD_W-1:0]  prod [3];

  assign rcp  = recip(count);
  assign free = !m_tvalid || m_tready;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(sums[ch]) * PROD_W'(rcp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata[CH_W-1:0]        <= prod[2][RECIP_SHIFT +: CH_W];
      m_tdata[2*CH_W-1:CH_W]   <= prod[1][RECIP_SHIFT +: CH_W];
      m_tdata[3*CH_W-1:2*CH_W] <= prod[0][RECIP_SHIFT +: CH_W];
      m_tlast                  <= eof;
    end
  end

endmodule

// File: design/rbb_checker.sv
// port-level checks for the rgb box blur, bound to the top level
module rbb_checker import rbb_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [PIX_W-1:0]       m_tdata,
  input logic                   m_tlast
);

  // output word holds while stalled
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // nothing pending on the output right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // one word at a time: busy right after taking a word
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  // a new result never rises unless the window update and sum steps lie between it and the last accept
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready, 1) && !$past(s_tvalid && s_tready, 2))
    else $error("result appeared too soon after accept");

endmodule

bind rgb_box_blur_3x3_edge_normalized rbb_checker u_rbb_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);
